>>> rtl/core/cgil_pkg.sv
// Shared types and constants for the cmap glyph index lookup unit.
`default_nettype none
package cgil_pkg;
    localparam logic [3:0] FMT_4  = 4'd4;
    localparam logic [3:0] FMT_6  = 4'd6;
    localparam logic [3:0] FMT_10 = 4'd10;
    localparam logic [3:0] FMT_12 = 4'd12;
    localparam logic [3:0] FMT_13 = 4'd13;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [0:0] CFG_FORMAT   = 1'd0;
    localparam logic [0:0] CFG_SEGCOUNT = 1'd1;

    localparam int AW = 34;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_DISPATCH,
        ST_F4_PROBE,
        ST_F4_CMP,
        ST_F4_SEG,
        ST_F4_SEG_W,
        ST_F4_RO,
        ST_F4_RO_W,
        ST_F4_GLYPH,
        ST_F4_GLYPH_W,
        ST_ARR_HDR,
        ST_ARR_HDR_W,
        ST_ARR_RD,
        ST_ARR_RD_W,
        ST_GRP_HDR,
        ST_GRP_HDR_W,
        ST_GRP_LOOP,
        ST_GRP_PROBE,
        ST_GRP_PROBE_W,
        ST_GRP_MATCH,
        ST_DONE
    } cgil_state_t;

    typedef enum logic [3:0] {
        RD_NONE,
        RD_F4_END,
        RD_F4_SEG,
        RD_F4_RO,
        RD_F4_GLYPH,
        RD_ARR_HDR,
        RD_ARR_ELEM,
        RD_GRP_HDR,
        RD_GRP_PROBE
    } cgil_read_t;

    typedef struct packed {
        logic       write_word;
        logic       load_code;
        logic       start_read;
        cgil_read_t read_kind;
        logic [2:0] read_step;
        logic       f4_init;
        logic       f4_cmp;
        logic       ro_calc;
        logic       arr_check;
        logic       grp_init;
        logic       grp_mid;
        logic       grp_cmp;
        logic       grp_match;
        logic       clear_result;
    } cgil_cmd_t;

    typedef struct packed {
        logic search_open;
        logic f4_code_big;
        logic f4_miss;
        logic f4_ro_zero;
        logic arr_miss;
        logic grp_found;
    } cgil_status_t;
endpackage
`default_nettype wire

>>> rtl/core/cmap_glyph_index_lookup_unit.sv
// Top level of the cmap glyph index lookup unit.
// Usage:
//   Input channel s_*: operation 0 writes word_data at word_address of the
//   cmap subtable memory; operation 1 looks up char_code in the loaded table.
//   Result channel m_*: one glyph_number per lookup, none per write.
//   Configuration: cfg_we with cfg_index 0 sets table_format, index 1 sets
//   segment_count; write only while the unit is idle.
// Sequencing:
//   After a write the next item can follow at once. Lookups are serialized
//   on the single table memory port: formats 6/10 stop early when the code
//   is outside the array; format 4 binary-searches the segments and reads
//   the glyph array only for a nonzero range offset; formats 12/13 search
//   the groups; format 4 codes above 0xFFFF and unsupported formats read
//   no table word. s_ready rises in the cycle after the result is taken.
// Reset: aresetn (synchronous, active low) clears the controller, the
//   configuration and the search bounds; the table memory is not cleared.
// Stall: a result is held on m_* until m_ready; no new item is taken while
//   a result waits.
`default_nettype none
module cmap_glyph_index_lookup_unit #(
    parameter int TABLE_WORDS = 8192
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [11:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_operation,
    input  wire  [12:0] s_word_address,
    input  wire  [15:0] s_word_data,
    input  wire  [20:0] s_char_code,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [15:0] m_glyph_number
);
    import cgil_pkg::*;

    logic [3:0]   table_format_reg;
    logic [11:0]  segment_count_reg;
    cgil_cmd_t    cmd;
    cgil_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_format_reg  <= '0;
            segment_count_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_FORMAT) table_format_reg <= cfg_data[3:0];
            if (cfg_index == CFG_SEGCOUNT) segment_count_reg <= cfg_data;
        end
    end

    cgil_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .table_format (table_format_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .status       (status)
    );

    cgil_datapath #(.TABLE_WORDS(TABLE_WORDS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .table_format   (table_format_reg),
        .segment_count  (segment_count_reg),
        .s_word_address (s_word_address),
        .s_word_data    (s_word_data),
        .s_char_code    (s_char_code),
        .glyph_reg      (m_glyph_number)
    );
endmodule
`default_nettype wire

>>> rtl/core/cgil_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module cgil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> rtl/core/cgil_datapath.sv
// Datapath: table memory, search bounds, address generation and glyph result.
`default_nettype none
module cgil_datapath #(
    parameter int TABLE_WORDS = 8192
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  cgil_pkg::cgil_cmd_t    cmd,
    output cgil_pkg::cgil_status_t status,
    input  wire  [3:0]             table_format,
    input  wire  [11:0]            segment_count,
    input  wire  [12:0]            s_word_address,
    input  wire  [15:0]            s_word_data,
    input  wire  [20:0]            s_char_code,
    output logic [15:0]            glyph_reg
);
    import cgil_pkg::*;

    localparam int RAW = $clog2(TABLE_WORDS);

    logic [AW-1:0]  rd_addr;
    logic           in_range_reg;
    logic [15:0]    ram_q;
    logic [15:0]    rd_word;
    logic [RAW-1:0] ram_addr;
    logic           ram_we;

    logic [20:0]    code_reg;
    logic [31:0]    lo_reg, lo_next;
    logic [31:0]    hi_reg, hi_next;
    logic [31:0]    mid_reg;
    logic [15:0]    w0_reg, w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;
    logic [31:0]    v_a, v_b, v_c;
    logic [33:0]    base_reg;
    logic [15:0]    glyph_next;
    logic [33:0]    sc;

    assign sc = {22'd0, segment_count};
    assign ram_we = cmd.write_word && ({20'd0, s_word_address} < TABLE_WORDS);

    always_comb begin
        rd_addr = '0;
        unique case (cmd.read_kind)
            RD_F4_END:   rd_addr = 34'd7 + {2'd0, mid_reg};
            RD_F4_SEG: begin
                if (cmd.read_step == 3'd0) rd_addr = 34'd7 + {2'd0, lo_reg};
                else rd_addr = 34'd8 + {2'd0, lo_reg} + sc * {31'd0, cmd.read_step};
            end
            RD_F4_RO:    rd_addr = 34'd8 + {2'd0, lo_reg} + sc * 34'd3;
            RD_F4_GLYPH: rd_addr = base_reg;
            // word 9 lands in w2 for the format 10 count
            RD_ARR_HDR:  rd_addr = (cmd.read_step == 3'd2) ? 34'd9
                                 : 34'd3 + {31'd0, cmd.read_step};
            RD_ARR_ELEM: rd_addr = base_reg;
            RD_GRP_HDR:  rd_addr = 34'd6 + {31'd0, cmd.read_step};
            RD_GRP_PROBE: rd_addr = base_reg + {31'd0, cmd.read_step};
            default:     rd_addr = '0;
        endcase
    end

    assign ram_addr = cmd.write_word ? RAW'(s_word_address) : rd_addr[RAW-1:0];

    cgil_ram #(.WIDTH(16), .DEPTH(TABLE_WORDS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_word_data),
        .rdata (ram_q)
    );

    assign rd_word = in_range_reg ? ram_q : 16'd0;

    always_ff @(posedge aclk) begin
        in_range_reg <= rd_addr < TABLE_WORDS;
    end

    assign v_a = {w0_reg, w1_reg};
    assign v_b = {w2_reg, w3_reg};
    assign v_c = {w4_reg, w5_reg};

    // word capture: registered read data goes to the w register picked by the read step
    logic       cap_en_reg;
    logic [2:0] cap_step_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_en_reg <= 1'b0;
        end else begin
            cap_en_reg <= cmd.start_read;
        end
        cap_step_reg <= cmd.read_step;
        if (cap_en_reg) begin
            unique case (cap_step_reg)
                3'd0: w0_reg <= rd_word;
                3'd1: w1_reg <= rd_word;
                3'd2: w2_reg <= rd_word;
                3'd3: w3_reg <= rd_word;
                3'd4: w4_reg <= rd_word;
                3'd5: w5_reg <= rd_word;
                default: w0_reg <= rd_word;
            endcase
        end
    end

    logic [33:0] diff4;
    logic [31:0] c32;
    assign c32 = {11'd0, code_reg};
    assign diff4 = {18'd0, code_reg[15:0] - w1_reg};

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        glyph_next = glyph_reg;
        if (cmd.f4_init) begin
            lo_next = '0;
            hi_next = {20'd0, segment_count};
        end
        if (cmd.f4_cmp) begin
            if (c32 > {16'd0, w0_reg}) lo_next = mid_reg + 32'd1;
            else hi_next = mid_reg;
        end
        if (cmd.grp_init) begin
            lo_next = '0;
            hi_next = v_a;
        end
        if (cmd.grp_cmp) begin
            if (c32 < v_a) hi_next = mid_reg;
            else if (c32 > v_b) lo_next = mid_reg + 32'd1;
        end
        if (cmd.grp_match) begin
            lo_next = mid_reg;
            hi_next = mid_reg;
            glyph_next = (table_format == FMT_13) ? w5_reg
                       : (v_c[15:0] + (code_reg[15:0] - w1_reg));
        end
        if (cmd.clear_result) glyph_next = '0;
        if (cmd.read_kind == RD_NONE && cmd.ro_calc && w3_reg == 16'd0) begin
            glyph_next = code_reg[15:0] + w2_reg;
        end
        if (cmd.read_kind == RD_F4_GLYPH && cmd.arr_check) begin
            glyph_next = (w4_reg == 16'd0) ? 16'd0 : (w4_reg + w2_reg);
        end
        if (cmd.read_kind == RD_ARR_ELEM && cmd.arr_check) begin
            glyph_next = w4_reg;
        end
    end

    logic [31:0] first_v, count_v, off_v;
    assign first_v = (table_format == FMT_6) ? {16'd0, w0_reg} : {w3_reg, w4_reg};
    assign count_v = (table_format == FMT_6) ? {16'd0, w1_reg} : {w5_reg, w2_reg};
    assign off_v   = c32 - first_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            glyph_reg <= '0;
        end else begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            glyph_reg <= glyph_next;
        end
        if (cmd.load_code) code_reg <= s_char_code;
        mid_reg <= lo_next + ((hi_next - lo_next) >> 1);
        if (cmd.ro_calc) begin
            base_reg <= 34'd8 + {2'd0, lo_reg} + sc * 34'd3 + {19'd0, w3_reg[15:1]} + diff4;
        end
        if (cmd.arr_check) begin
            base_reg <= ((table_format == FMT_6) ? 34'd5 : 34'd10) + {2'd0, off_v};
        end
        if (cmd.grp_mid) begin
            base_reg <= 34'd8 + {2'd0, mid_reg} * 34'd6;
        end
    end

    assign status.search_open = lo_reg < hi_reg;
    assign status.f4_code_big = code_reg > 21'h00FFFF;
    assign status.f4_miss = ({20'd0, segment_count} <= lo_reg)
                         || (code_reg[15:0] < w1_reg) || (code_reg[15:0] > w0_reg);
    assign status.f4_ro_zero = w3_reg == 16'd0;
    assign status.arr_miss = (c32 < first_v) || (off_v >= count_v);
    assign status.grp_found = !(c32 < v_a) && !(c32 > v_b);
endmodule
`default_nettype wire

>>> rtl/core/cgil_ctrl.sv
// Controller: sequences writes, header reads, binary search probes and glyph reads.
`default_nettype none
module cgil_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_operation,
    input  wire  [3:0]             table_format,
    output logic                   m_valid,
    input  wire                    m_ready,
    output cgil_pkg::cgil_cmd_t    cmd,
    input  cgil_pkg::cgil_status_t status
);
    import cgil_pkg::*;

    cgil_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        mvalid_reg, mvalid_next;

    assign m_valid = mvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        mvalid_next = mvalid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !mvalid_reg) begin
                    state_next = (s_operation == OP_WRITE) ? ST_IDLE : ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                step_next = '0;
                unique case (table_format)
                    FMT_4:  state_next = status.f4_code_big ? ST_DONE : ST_F4_PROBE;
                    FMT_6, FMT_10: state_next = ST_ARR_HDR;
                    FMT_12, FMT_13: state_next = ST_GRP_HDR;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_F4_PROBE: state_next = status.search_open ? ST_F4_CMP : ST_F4_SEG;
            ST_F4_CMP:   state_next = ST_F4_GLYPH_W;
            ST_F4_GLYPH_W: state_next = ST_F4_PROBE;
            ST_F4_SEG: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) state_next = ST_F4_SEG_W;
            end
            ST_F4_SEG_W: state_next = ST_F4_RO;
            ST_F4_RO: begin
                if (status.f4_miss) state_next = ST_DONE;
                else if (status.f4_ro_zero) state_next = ST_DONE;
                else state_next = ST_F4_RO_W;
            end
            ST_F4_RO_W:  state_next = ST_F4_GLYPH;
            ST_F4_GLYPH: state_next = ST_WRITE;
            ST_WRITE:    state_next = ST_DONE;
            ST_ARR_HDR: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) state_next = ST_ARR_HDR_W;
            end
            ST_ARR_HDR_W: state_next = ST_ARR_RD;
            ST_ARR_RD:   state_next = status.arr_miss ? ST_DONE : ST_ARR_RD_W;
            ST_ARR_RD_W: state_next = ST_F4_RO_W;
            ST_GRP_HDR: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) state_next = ST_GRP_HDR_W;
            end
            ST_GRP_HDR_W: state_next = ST_GRP_LOOP;
            ST_GRP_LOOP: begin
                step_next = '0;
                state_next = status.search_open ? ST_GRP_PROBE : ST_DONE;
            end
            ST_GRP_PROBE: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) state_next = ST_GRP_PROBE_W;
            end
            ST_GRP_PROBE_W: state_next = status.grp_found ? ST_GRP_MATCH : ST_GRP_LOOP;
            ST_GRP_MATCH: state_next = ST_DONE;
            ST_DONE: begin
                state_next = ST_IDLE;
                mvalid_next = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !mvalid_reg;
                cmd.load_code = 1'b1;
                cmd.write_word = s_valid && !mvalid_reg && (s_operation == OP_WRITE);
            end
            ST_DISPATCH: begin
                cmd.clear_result = 1'b1;
                cmd.f4_init = (table_format == FMT_4);
            end
            ST_F4_PROBE: begin
                cmd.start_read = 1'b1;
                cmd.read_kind = RD_F4_END;
            end
            ST_F4_CMP: cmd.read_kind = RD_NONE;
            ST_F4_GLYPH_W: cmd.f4_cmp = 1'b1;
            ST_F4_SEG: begin
                cmd.start_read = 1'b1;
                cmd.read_kind = RD_F4_SEG;
                cmd.read_step = step_reg;
            end
            ST_F4_RO: begin
                cmd.ro_calc = !status.f4_miss;
                cmd.read_kind = RD_NONE;
            end
            ST_F4_RO_W: begin
                cmd.start_read = 1'b1;
                cmd.read_kind = RD_F4_GLYPH;
                cmd.read_step = 3'd4;
            end
            ST_WRITE: begin
                cmd.read_kind = RD_F4_GLYPH;
                cmd.arr_check = (table_format == FMT_4);
                if (table_format != FMT_4) cmd.read_kind = RD_ARR_ELEM;
                cmd.arr_check = 1'b1;
            end
            ST_ARR_HDR: begin
                cmd.start_read = 1'b1;
                cmd.read_kind = RD_ARR_HDR;
                cmd.read_step = step_reg;
            end
            ST_ARR_RD: cmd.arr_check = 1'b1;
            ST_GRP_HDR: begin
                cmd.start_read = 1'b1;
                cmd.read_kind = RD_GRP_HDR;
                cmd.read_step = step_reg;
            end
            ST_GRP_HDR_W: cmd.grp_init = 1'b1;
            ST_GRP_LOOP: cmd.grp_mid = 1'b1;
            ST_GRP_PROBE: begin
                cmd.start_read = 1'b1;
                cmd.read_kind = RD_GRP_PROBE;
                cmd.read_step = step_reg;
            end
            ST_GRP_PROBE_W: cmd.grp_cmp = 1'b1;
            ST_GRP_MATCH: cmd.grp_match = 1'b1;
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> tb/cmap_glyph_index_lookup_unit_checker.sv
// Glyph lookup predictor and result checker for the cmap lookup unit.
module cmap_glyph_index_lookup_unit_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [11:0] cfg_data,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire         s_operation,
    input  wire  [12:0] s_word_address,
    input  wire  [15:0] s_word_data,
    input  wire  [20:0] s_char_code,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [15:0] m_glyph_number,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import cgil_pkg::*;

    localparam longint unsigned MEM_WORDS = 8192;

    logic [15:0] words [MEM_WORDS];
    logic [3:0]  fmt;
    logic [11:0] seg_cnt;
    logic [15:0] glyphs_due [$];

    function automatic longint unsigned word_at(longint unsigned w);
        if (w >= MEM_WORDS) return 0;
        return words[w];
    endfunction

    function automatic longint unsigned dword_at(longint unsigned w);
        return (word_at(w) << 16) | word_at(w + 1);
    endfunction

    function automatic logic [15:0] segment_glyph(longint unsigned code);
        longint unsigned n, lo, hi, mid, st, en, dl, ro, g;
        n = seg_cnt;
        lo = 0;
        hi = n;
        if (code > 'hFFFF) return 16'd0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (code > word_at(7 + mid)) lo = mid + 1;
            else hi = mid;
        end
        if (lo >= n) return 16'd0;
        en = word_at(7 + lo);
        st = word_at(8 + n + lo);
        dl = word_at(8 + 2 * n + lo);
        ro = word_at(8 + 3 * n + lo);
        if (code < st || code > en) return 16'd0;
        if (ro == 0) return 16'(code + dl);
        g = word_at(8 + 3 * n + lo + (ro >> 1) + (code - st));
        if (g != 0) g = g + dl;
        return 16'(g);
    endfunction

    function automatic logic [15:0] group_glyph(longint unsigned code, bit constant_id);
        longint unsigned lo, hi, mid, gw, st, en, gid, res;
        lo = 0;
        hi = dword_at(6);
        res = 0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            gw = 8 + mid * 6;
            st = dword_at(gw);
            en = dword_at(gw + 2);
            if (code < st) begin
                hi = mid;
            end else if (code > en) begin
                lo = mid + 1;
            end else begin
                gid = dword_at(gw + 4);
                res = constant_id ? gid : gid + (code - st);
                break;
            end
        end
        return 16'(res);
    endfunction

    function automatic logic [15:0] array_glyph(longint unsigned code, bit wide);
        longint unsigned first, count, base;
        first = wide ? dword_at(6) : word_at(3);
        count = wide ? dword_at(8) : word_at(4);
        base  = wide ? 10 : 5;
        if (code < first || code - first >= count) return 16'd0;
        return 16'(word_at(base + code - first));
    endfunction

    function automatic logic [15:0] glyph_for(logic [20:0] code);
        case (fmt)
            FMT_4:   return segment_glyph(code);
            FMT_6:   return array_glyph(code, 1'b0);
            FMT_10:  return array_glyph(code, 1'b1);
            FMT_12:  return group_glyph(code, 1'b0);
            FMT_13:  return group_glyph(code, 1'b1);
            default: return 16'd0;
        endcase
    endfunction

    initial begin
        mismatches = 0;
        outstanding = 0;
        fmt = '0;
        seg_cnt = '0;
    end

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            fmt = '0;
            seg_cnt = '0;
            glyphs_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (glyphs_due.size() == 0) begin
                    $display("%0t ERROR glyph expected none got %0d", $time, m_glyph_number);
                    mismatches++;
                end else begin
                    want = glyphs_due.pop_front();
                    if (m_glyph_number !== want) begin
                        $display("%0t ERROR glyph expected %0d got %0d",
                                 $time, want, m_glyph_number);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_WRITE) words[s_word_address] = s_word_data;
                else glyphs_due.push_back(glyph_for(s_char_code));
            end
            if (cfg_we) begin
                if (cfg_index == CFG_FORMAT) fmt = cfg_data[3:0];
                else seg_cnt = cfg_data;
            end
        end
        outstanding = glyphs_due.size();
    end
endmodule

>>> tb/cmap_glyph_index_lookup_unit_test.sv
// Stimulus and verdict for the cmap glyph index lookup unit.
module cmap_glyph_index_lookup_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cgil_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [12:0] s_word_address;
    logic [15:0] s_word_data;
    logic [20:0] s_char_code;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_glyph_number;
    int          mismatches;
    int          outstanding;
    int          quiet;
    bit          idle_on;
    bit          long_hold;
    int unsigned range_lo [$];
    int unsigned range_hi [$];

    cmap_glyph_index_lookup_unit dut (.*);

    cmap_glyph_index_lookup_unit_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAIL cmap_glyph_index_lookup_unit");
                $finish;
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                long_hold = 0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send(logic op, logic [12:0] addr, logic [15:0] data, logic [20:0] code);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_word_address <= addr;
        s_word_data <= data;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic put_word(int unsigned addr, int unsigned data);
        send(OP_WRITE, 13'(addr), 16'(data), 21'($urandom));
    endtask

    task automatic look_up(int unsigned code);
        send(OP_LOOKUP, 13'($urandom), 16'($urandom), 21'(code));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_table(logic [3:0] fmt, logic [11:0] segs);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FORMAT;
        cfg_data <= 12'(fmt);
        @(negedge aclk);
        cfg_index <= CFG_SEGCOUNT;
        cfg_data <= segs;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_segments(int unsigned n);
        int unsigned cur, st, en, gb, ro_pos, span;
        cur = $urandom_range(0, 1000);
        gb = 8 + 4 * n;
        range_lo.delete();
        range_hi.delete();
        for (int unsigned i = 0; i < n; i++) begin
            st = cur;
            en = (i == n - 1) ? 'hFFFF : st + $urandom_range(0, 15);
            cur = en + 1 + $urandom_range(0, 40);
            ro_pos = 8 + 3 * n + i;
            put_word(7 + i, en);
            put_word(8 + n + i, st);
            put_word(8 + 2 * n + i, $urandom);
            range_lo.push_back(st);
            range_hi.push_back((en - st > 40) ? st + 40 : en);
            if (i != n - 1 && $urandom_range(0, 1)) begin
                put_word(ro_pos, 2 * (gb - ro_pos));
                span = (en - st > 31) ? 31 : en - st;
                for (int unsigned k = 0; k <= span; k++)
                    put_word(gb + k, ($urandom_range(0, 3) == 0) ? 0 : $urandom);
                gb += span + 1;
            end else begin
                // a nonzero offset here points past the table
                put_word(ro_pos, ($urandom_range(0, 5) == 0) ? $urandom_range('h4000, 'hFFFF) : 0);
            end
        end
    endtask

    task automatic build_array(bit wide);
        int unsigned first, count;
        first = wide ? $urandom_range(0, 'h1FFFC0) : $urandom_range(0, 'hFFFF);
        count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
        if (wide) begin
            put_word(6, first >> 16);
            put_word(7, first);
            put_word(8, 0);
            put_word(9, count);
        end else begin
            put_word(3, first);
            put_word(4, count);
        end
        for (int unsigned i = 0; i < count; i++) put_word((wide ? 10 : 5) + i, $urandom);
        range_lo.delete();
        range_hi.delete();
        range_lo.push_back(first);
        range_hi.push_back(first + count);
    endtask

    task automatic build_groups(int unsigned ng);
        int unsigned cur, st, en, gid;
        cur = ($urandom_range(0, 1)) ? $urandom_range(0, 5000) : $urandom_range(0, 'h1FF000);
        put_word(6, 0);
        put_word(7, ng);
        range_lo.delete();
        range_hi.delete();
        for (int unsigned i = 0; i < ng; i++) begin
            st = cur;
            en = st + $urandom_range(0, 30);
            cur = en + 1 + $urandom_range(0, 50);
            gid = $urandom;
            put_word(8 + 6 * i, st >> 16);
            put_word(9 + 6 * i, st);
            put_word(10 + 6 * i, en >> 16);
            put_word(11 + 6 * i, en);
            put_word(12 + 6 * i, gid >> 16);
            put_word(13 + 6 * i, gid);
            range_lo.push_back(st);
            range_hi.push_back(en);
        end
    endtask

    function automatic int unsigned pick_code();
        int unsigned k, lo;
        if (range_lo.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, range_lo.size() - 1);
            lo = (range_lo[k] > 0) ? range_lo[k] - 1 : 0;
            return $urandom_range(lo, range_hi[k] + 1) & 'h1FFFFF;
        end
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 'hFFFF;
            2: return 'h10000;
            3: return 'h1FFFFF;
            default: return $urandom & 'h1FFFFF;
        endcase
    endfunction

    initial begin
        logic [3:0] fmt;
        int unsigned n;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_operation = OP_WRITE;
        s_word_address = '0;
        s_word_data = '0;
        s_char_code = '0;
        idle_on = 0;
        long_hold = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // low table region defined before any lookup
        for (int unsigned a = 0; a < 256; a++) put_word(a, 0);
        settle();

        // directed: one segment covering everything, then edges
        set_table(FMT_4, 12'd1);
        put_word(7, 'hFFFF);
        put_word(9, 0);
        put_word(10, 'hFFFF);
        put_word(11, 0);
        look_up(0);
        look_up('h41);
        look_up('hFFFF);
        look_up('h10000);
        look_up('h1FFFFF);
        settle();
        set_table(4'd0, 12'd0);
        look_up('h41);
        settle();
        set_table(4'd15, 12'hFFF);
        look_up('h41);
        settle();
        set_table(FMT_4, 12'd60);
        look_up(0);
        look_up('hFFFF);
        look_up('h1234);
        settle();
        set_table(FMT_4, 12'd0);
        look_up('h20);
        settle();

        idle_on = 1;
        for (int p = 0; p < 10; p++) begin
            if (p == 9) idle_on = 0;
            case (p % 5)
                0: fmt = FMT_4;
                1: fmt = FMT_6;
                2: fmt = FMT_10;
                3: fmt = FMT_12;
                default: fmt = FMT_13;
            endcase
            n = $urandom_range(1, 12);
            set_table(fmt, (fmt == FMT_4) ? 12'(n) : 12'($urandom));
            case (fmt)
                FMT_4:   build_segments(n);
                FMT_6:   build_array(1'b0);
                FMT_10:  build_array(1'b1);
                default: build_groups($urandom_range(1, 20));
            endcase
            if (p == 6) long_hold = 1;
            for (int i = 0; i < 50; i++) look_up(pick_code());
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS cmap_glyph_index_lookup_unit");
        end else begin
            $display("FAIL cmap_glyph_index_lookup_unit");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/cgil_pkg.sv
rtl/core/cgil_ram.sv
rtl/core/cgil_datapath.sv
rtl/core/cgil_ctrl.sv
rtl/core/cmap_glyph_index_lookup_unit.sv
tb/cmap_glyph_index_lookup_unit_checker.sv
tb/cmap_glyph_index_lookup_unit_test.sv
